>>> sv/alle_pkg.sv
`default_nettype none

package alle_pkg;

  localparam int OP_W     = 3;
  localparam int SLOT_W   = 10;
  localparam int ITEM_W   = 32;
  localparam int STATUS_W = 2;

  localparam logic [OP_W-1:0] OP_INS_AFTER  = 3'd0;
  localparam logic [OP_W-1:0] OP_INS_BEFORE = 3'd1;
  localparam logic [OP_W-1:0] OP_INS_FRONT  = 3'd2;
  localparam logic [OP_W-1:0] OP_INS_BACK   = 3'd3;
  localparam logic [OP_W-1:0] OP_REMOVE     = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_WRONG = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

endpackage

`default_nettype wire

>>> sv/alle_if.sv
`default_nettype none

interface alle_in_if;
  logic                       valid;
  logic                       ready;
  logic [alle_pkg::OP_W-1:0]   operation;
  logic [alle_pkg::SLOT_W-1:0] slot;
  logic [alle_pkg::ITEM_W-1:0] item_value;

  modport source (output valid, output operation, output slot, output item_value,
                  input ready);
  modport sink (input valid, input operation, input slot, input item_value,
                output ready);
endinterface

interface alle_out_if;
  logic                         valid;
  logic                         ready;
  logic [alle_pkg::SLOT_W-1:0]   used_slot;
  logic [alle_pkg::STATUS_W-1:0] status;
  logic [alle_pkg::SLOT_W-1:0]   head_slot;
  logic [alle_pkg::SLOT_W-1:0]   tail_slot;
  logic [alle_pkg::SLOT_W-1:0]   count;

  modport source (output valid, output used_slot, output status, output head_slot,
                  output tail_slot, output count, input ready);
  modport sink (input valid, input used_slot, input status, input head_slot,
                input tail_slot, input count, output ready);
endinterface

`default_nettype wire

>>> sv/alle_link_store.sv
`default_nettype none

module alle_link_store #(
  parameter int SLOTS = 1024,
  localparam int SW   = $clog2(SLOTS)
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          next_we,
  input  wire logic [SW-1:0] next_addr,
  input  wire logic [SW-1:0] next_wd,
  input  wire logic          prev_we,
  input  wire logic [SW-1:0] prev_addr,
  input  wire logic [SW-1:0] prev_wd,
  input  wire logic          use_we,
  input  wire logic [SW-1:0] use_addr,
  input  wire logic          use_wd,
  output logic      [SW-1:0] next_rd,
  output logic      [SW-1:0] prev_rd,
  output logic               use_rd,
  output logic      [SW-1:0] head,
  output logic      [SW-1:0] tail
);

  logic [SW-1:0] next_mem [SLOTS];
  logic [SW-1:0] prev_mem [SLOTS];
  logic          use_mem  [SLOTS];

  logic [SW-1:0] next_q, prev_q;
  logic          use_q;
  logic [SW-1:0] next_aq, prev_aq, use_aq;

  // Slots at or above the fill mark have never been allocated and still hold
  // their power-on links; the mark only moves up as fresh slots are taken.
  logic [SW:0]   mark_r;
  logic [SW-1:0] head_r, tail_r;

  always_ff @(posedge clk) begin
    if (next_we) begin
      next_mem[next_addr] <= next_wd;
    end
    if (prev_we) begin
      prev_mem[prev_addr] <= prev_wd;
    end
    if (use_we) begin
      use_mem[use_addr] <= use_wd;
    end
    next_q  <= next_mem[next_addr];
    prev_q  <= prev_mem[prev_addr];
    use_q   <= use_mem[use_addr];
    next_aq <= next_addr;
    prev_aq <= prev_addr;
    use_aq  <= use_addr;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mark_r <= (SW+1)'(1);
      head_r <= '0;
      tail_r <= '0;
    end else begin
      if (use_we && use_wd && ((SW+1)'(use_addr) >= mark_r)) begin
        mark_r <= (SW+1)'(use_addr) + (SW+1)'(1);
      end
      if (next_we && (next_addr == '0)) begin
        head_r <= next_wd;
      end
      if (prev_we && (prev_addr == '0)) begin
        tail_r <= prev_wd;
      end
    end
  end

  // The sentinel's links live in registers; untouched slots read as the
  // power-on free chain.
  always_comb begin
    if (next_aq == '0) begin
      next_rd = head_r;
    end else if ((SW+1)'(next_aq) >= mark_r) begin
      next_rd = (next_aq == SW'(SLOTS - 1)) ? '0 : next_aq + SW'(1);
    end else begin
      next_rd = next_q;
    end

    if (prev_aq == '0) begin
      prev_rd = tail_r;
    end else if ((SW+1)'(prev_aq) >= mark_r) begin
      prev_rd = '0;
    end else begin
      prev_rd = prev_q;
    end

    if (use_aq == '0) begin
      use_rd = 1'b1;
    end else if ((SW+1)'(use_aq) >= mark_r) begin
      use_rd = 1'b0;
    end else begin
      use_rd = use_q;
    end
  end

  assign head = head_r;
  assign tail = tail_r;

endmodule

`default_nettype wire

>>> sv/array_linked_list_engine.sv
`default_nettype none

// Doubly linked list of up to SLOTS-1 elements kept in index-linked slot memories,
// with slot 0 as the sentinel and unused slots on a free chain. A successful
// request passes through the states in order: the accepting cycle reads the slot's
// links, S_READ reads the free chain's next entry while the request is checked,
// S_WR_A and S_WR_B update the single-port link memories, and S_FIN loads the
// result register. A rejected request skips the write states and goes from S_READ
// to S_FIN. The block takes a new request as soon as the previous one has reached
// the result register, and only waits in S_FIN if that register is still full.
// Right after reset the block is ready: never-used slots are tracked by a fill
// mark, so no clearing pass is needed.
module array_linked_list_engine #(
  parameter int SLOTS      = 1024,
  parameter int VALUE_BITS = 32
) (
  input  wire logic clk,
  input  wire logic rst_n,
  alle_in_if.sink   in_ch,
  alle_out_if.source out_ch
);

  import alle_pkg::*;

  localparam int SW = $clog2(SLOTS);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_READ = 5'b00010,
    S_WR_A = 5'b00100,
    S_WR_B = 5'b01000,
    S_FIN  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  logic [OP_W-1:0]       op_r;
  logic [SW-1:0]         idx_r;
  logic [VALUE_BITS-1:0] val_r;
  logic                  range_r;
  logic [SW-1:0]         left_r, right_r, used_r;
  logic [STATUS_W-1:0]   status_r;

  logic [SW-1:0] free_head_r, free_head_nxt;
  logic [SW-1:0] free_left_r, free_left_nxt;
  logic [SW-1:0] count_r, count_nxt;
  logic          out_valid_r, out_valid_nxt;

  logic [SLOT_W-1:0]   out_used_r, out_head_r, out_tail_r, out_count_r;
  logic [STATUS_W-1:0] out_status_r;

  logic [VALUE_BITS-1:0] value_mem [SLOTS];

  logic          next_we, prev_we, use_we, use_wd;
  logic [SW-1:0] next_addr, next_wd, prev_addr, prev_wd, use_addr;
  logic [SW-1:0] next_rd, prev_rd, head, tail;
  logic          use_rd;

  logic          accept, is_end, is_ins, after_side, slot_ok, load_out;
  logic [SW-1:0] acc_idx;

  alle_link_store #(
    .SLOTS (SLOTS)
  ) u_store (
    .clk       (clk),
    .rst_n     (rst_n),
    .next_we   (next_we),
    .next_addr (next_addr),
    .next_wd   (next_wd),
    .prev_we   (prev_we),
    .prev_addr (prev_addr),
    .prev_wd   (prev_wd),
    .use_we    (use_we),
    .use_addr  (use_addr),
    .use_wd    (use_wd),
    .next_rd   (next_rd),
    .prev_rd   (prev_rd),
    .use_rd    (use_rd),
    .head      (head),
    .tail      (tail)
  );

  assign in_ch.ready = (state_r == S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;

  // Front and back are handled as insert after or before the sentinel.
  assign is_end  = (in_ch.operation == OP_INS_FRONT) || (in_ch.operation == OP_INS_BACK);
  assign acc_idx = is_end ? '0 : SW'(in_ch.slot);

  assign is_ins     = op_r inside {OP_INS_AFTER, OP_INS_BEFORE, OP_INS_FRONT, OP_INS_BACK};
  assign after_side = (op_r == OP_INS_AFTER) || (op_r == OP_INS_FRONT);
  assign slot_ok    = range_r && use_rd;
  assign load_out   = (state_r == S_FIN) && (!out_valid_r || out_ch.ready);

  function automatic logic status_nxt_ok();
    logic ok;
    ok = 1'b0;
    if (is_ins) begin
      ok = slot_ok && (free_left_r != '0);
    end else if (op_r == OP_REMOVE) begin
      ok = slot_ok && (idx_r != '0);
    end
    return ok;
  endfunction

  always_comb begin
    state_nxt     = state_r;
    free_head_nxt = free_head_r;
    free_left_nxt = free_left_r;
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r;

    next_we   = 1'b0;
    prev_we   = 1'b0;
    use_we    = 1'b0;
    use_wd    = 1'b0;
    next_addr = idx_r;
    next_wd   = '0;
    prev_addr = idx_r;
    prev_wd   = '0;
    use_addr  = idx_r;

    if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        next_addr = acc_idx;
        prev_addr = acc_idx;
        use_addr  = acc_idx;
        if (accept) begin
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        // Fetch the free chain's successor for the allocation step.
        next_addr = free_head_r;
        if (status_nxt_ok()) begin
          state_nxt = S_WR_A;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_WR_A: begin
        next_we   = 1'b1;
        next_addr = left_r;
        next_wd   = is_ins ? used_r : right_r;
        prev_we   = 1'b1;
        prev_addr = right_r;
        prev_wd   = is_ins ? used_r : left_r;
        use_we    = 1'b1;
        use_addr  = used_r;
        use_wd    = is_ins;
        if (is_ins) begin
          free_head_nxt = next_rd;
          free_left_nxt = free_left_r - SW'(1);
          count_nxt     = count_r + SW'(1);
        end
        state_nxt = S_WR_B;
      end
      S_WR_B: begin
        next_we   = 1'b1;
        next_addr = used_r;
        prev_we   = 1'b1;
        prev_addr = used_r;
        if (is_ins) begin
          next_wd = right_r;
          prev_wd = left_r;
        end else begin
          next_wd       = (free_left_r == '0) ? '0 : free_head_r;
          prev_wd       = '0;
          free_head_nxt = used_r;
          free_left_nxt = free_left_r + SW'(1);
          count_nxt     = count_r - SW'(1);
        end
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (load_out) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      free_head_r <= SW'(1);
      free_left_r <= SW'(SLOTS - 1);
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      free_head_r <= free_head_nxt;
      free_left_r <= free_left_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r    <= in_ch.operation;
      idx_r   <= acc_idx;
      val_r   <= VALUE_BITS'(in_ch.item_value);
      range_r <= is_end || ((SLOT_W+7)'(in_ch.slot) < (SLOT_W+7)'(SLOTS));
    end

    if (state_r == S_READ) begin
      if (!is_ins) begin
        left_r  <= prev_rd;
        right_r <= next_rd;
      end else if (after_side) begin
        left_r  <= idx_r;
        right_r <= next_rd;
      end else begin
        left_r  <= prev_rd;
        right_r <= idx_r;
      end

      if (is_ins) begin
        if (!slot_ok) begin
          status_r <= ST_WRONG;
          used_r   <= '0;
        end else if (free_left_r == '0) begin
          status_r <= ST_FULL;
          used_r   <= '0;
        end else begin
          status_r <= ST_OK;
          used_r   <= free_head_r;
        end
      end else if ((op_r == OP_REMOVE) && slot_ok && (idx_r != '0)) begin
        status_r <= ST_OK;
        used_r   <= idx_r;
      end else begin
        status_r <= ST_WRONG;
        used_r   <= '0;
      end
    end

    if ((state_r == S_WR_A) && is_ins) begin
      value_mem[used_r] <= val_r;
    end

    if (load_out) begin
      out_used_r   <= SLOT_W'(used_r);
      out_status_r <= status_r;
      out_head_r   <= SLOT_W'(head);
      out_tail_r   <= SLOT_W'(tail);
      out_count_r  <= SLOT_W'(count_r);
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.used_slot = out_used_r;
  assign out_ch.status    = out_status_r;
  assign out_ch.head_slot = out_head_r;
  assign out_ch.tail_slot = out_tail_r;
  assign out_ch.count     = out_count_r;

endmodule

`default_nettype wire
